[rtl/bfs_hop_distance_macros.svh]
// Assertion macros for the hop distance block.
// Define ASSERT_OFF to compile them away.
`ifndef BFS_HOP_DISTANCE_MACROS_SVH
`define BFS_HOP_DISTANCE_MACROS_SVH
`ifndef ASSERT_OFF
`define BHD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BHD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BHD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BHD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/bhd_pkg.sv]
// Shared codes and types of the hop distance block.
// No dependencies.
package bhd_pkg;
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_TWO_WAY      = 1'b1;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] vertex;
    logic [5:0] distance;
    logic       reached;
    logic       last;
  } result_t;
endpackage

[rtl/bhd_out_skid.sv]
// Output register stage for result transactions.
// Depends on bhd_pkg.
module bhd_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bhd_pkg::result_t push_data,
  output logic             full,
  output logic             out_tvalid,
  input  logic             out_tready,
  output bhd_pkg::result_t out_data
);
  import bhd_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign full       = valid_r && !out_tready;
  assign out_tvalid = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end
endmodule

[rtl/bfs_hop_distance.sv]
// Breadth-first hop distance engine: top level with graph memories and search sequencer.
// Depends on bhd_pkg, bhd_out_skid and bfs_hop_distance_macros.svh.
//
// An add edge transaction reads the old list head and links a new entry
// (S_LHEAD, S_LINK) once per stored direction, then gives its result in
// S_RESP; a dropped edge and a clear go straight to S_RESP. A search pops
// each reached vertex, walks its list entries and then reports every vertex,
// and it waits on output stalls. Each list entry is fetched through the entry
// memory's single read port, whose read data are registered. One result
// transaction comes out per reported vertex. Clearing drops every list head
// through one valid bit per vertex, and each search resets its visit marks
// the same way, so no clearing pass follows reset.
`include "bfs_hop_distance_macros.svh"
module bfs_hop_distance #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_ENTRIES  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: func[1:0], first_vertex[7:2], second_vertex[13:8], zero [15:14]
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: status[1:0], vertex[7:2], distance[13:8], reached[14], zero [15]
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import bhd_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] ENTRY_MAX = CW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_LHEAD, S_LINK, S_RESP, S_QPOP, S_HEAD, S_ENT_RD, S_ENT_CHK,
    S_OUT_RD, S_OUT_WR
  } state_t;

  // Memories.
  logic [CW-1:0] head_mem [MAX_VERTICES];
  logic [5:0]    nb_mem   [MAX_ENTRIES];
  logic [CW-1:0] next_mem [MAX_ENTRIES];
  logic [5:0]    hop_mem  [MAX_VERTICES];
  logic [VW-1:0] queue_mem[MAX_VERTICES];
  // One valid bit per list head and one visit mark per vertex, kept in flops.
  logic [MAX_VERTICES-1:0] head_vld_r;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;

  logic [6:0] vcount_r;
  logic       two_way_r;
  logic [CW-1:0] used_r;

  state_t        state_r;
  logic [VW-1:0] la_r, lb_r;
  logic          second_r;
  logic [1:0]    rstat_r;
  logic [6:0]    qh_r, qt_r;
  logic [5:0]    curhop_r;
  logic [CW-1:0] e_r;
  logic [6:0]    ov_r;
  logic [5:0]    rd_nb_r;
  logic [CW-1:0] rd_next_r;
  logic [CW-1:0] rd_head_r;
  logic          rd_hvld_r;
  logic [5:0]    rd_hop_r;
  logic [VW-1:0] rd_q_r;

  logic [6:0] count;
  always_comb begin
    if (vcount_r == 7'd0) count = 7'd1;
    else if (vcount_r > 7'(MAX_VERTICES)) count = 7'(MAX_VERTICES);
    else count = vcount_r;
  end

  func_t      func;
  logic [5:0] fa, fb;
  assign func = func_t'(in_tdata[1:0]);
  assign fa   = in_tdata[7:2];
  assign fb   = in_tdata[13:8];

  logic    push, skid_full;
  result_t push_data, out_res;

  bhd_out_skid u_skid (
    .clk, .rst_n, .push, .push_data, .full(skid_full),
    .out_tvalid, .out_tready, .out_data(out_res)
  );
  assign out_tdata = {1'b0, out_res.reached, out_res.distance, out_res.vertex,
                      out_res.status};
  assign out_tlast = out_res.last;

  assign in_tready = (state_r == S_IDLE);
  logic acc;
  assign acc = in_tvalid && in_tready;

  logic [CW-1:0] cur_head;
  assign cur_head = rd_hvld_r ? rd_head_r : ENTRY_MAX;
  logic nb_vis;
  assign nb_vis = vis_r[rd_nb_r[VW-1:0]];
  logic ov_vis;
  assign ov_vis = vis_r[ov_r[VW-1:0]];

  // Entry to fetch: the list head on the first step, then the chained entry.
  logic [CW-1:0] e_nxt;
  logic [EW-1:0] ent_ra;
  assign e_nxt  = second_r ? rd_next_r : cur_head;
  assign ent_ra = (state_r == S_ENT_RD) ? e_nxt[EW-1:0] : e_r[EW-1:0];

  logic [CW-1:0] need;
  assign need = two_way_r ? CW'(2) : CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r  <= 7'd64;
      two_way_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT: vcount_r <= cfg_data;
        CFG_TWO_WAY:      two_way_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Memory write side, driven by the sequencer below.
  logic          hd_we, nb_we, vis_we, vis_clr, hop_we, q_we;
  logic [VW-1:0] hd_wa, vis_wa, hop_wa, q_wa;
  logic [5:0]    hop_wd;
  logic [VW-1:0] q_wd;
  logic [VW-1:0] link_from;
  logic [5:0]    link_to;
  assign link_from = second_r ? lb_r : la_r;
  assign link_to   = 6'(second_r ? la_r : lb_r);

  always_comb begin
    hd_we = 1'b0; nb_we = 1'b0; vis_we = 1'b0; vis_clr = 1'b0; hop_we = 1'b0;
    q_we = 1'b0;
    hd_wa = link_from; vis_wa = rd_nb_r[VW-1:0]; hop_wa = rd_nb_r[VW-1:0];
    hop_wd = curhop_r + 6'd1; q_wa = qt_r[VW-1:0]; q_wd = rd_nb_r[VW-1:0];
    case (state_r)
      S_IDLE: begin
        if (acc && func == FUNC_RUN && 7'(fa) < count) begin
          vis_clr = 1'b1;
          vis_we = 1'b1; vis_wa = fa[VW-1:0];
          hop_we = 1'b1; hop_wa = fa[VW-1:0]; hop_wd = 6'd0;
          q_we = 1'b1; q_wa = '0; q_wd = fa[VW-1:0];
        end
      end
      S_LINK: begin
        hd_we = 1'b1; nb_we = 1'b1;
      end
      S_ENT_CHK: begin
        if (e_r < used_r && 7'(rd_nb_r) < count && !nb_vis &&
            qt_r < 7'(MAX_VERTICES)) begin
          vis_we = 1'b1; hop_we = 1'b1; q_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    vis_nxt = vis_clr ? '0 : vis_r;
    if (vis_we) vis_nxt[vis_wa] = 1'b1;
  end

  // The head read is issued in S_LHEAD so that the old head is chained
  // behind the new entry in S_LINK.
  logic [VW-1:0] hd_ra, hop_ra;
  assign hd_ra  = (state_r == S_HEAD) ? rd_q_r : link_from;
  assign hop_ra = (state_r == S_HEAD) ? rd_q_r : ov_r[VW-1:0];

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[hd_wa] <= used_r;
    end
    rd_head_r <= head_mem[hd_ra];
    rd_hvld_r <= head_vld_r[hd_ra];
    if (nb_we) begin
      nb_mem[used_r[EW-1:0]]   <= link_to;
      next_mem[used_r[EW-1:0]] <= rd_hvld_r ? rd_head_r : ENTRY_MAX;
    end
    rd_nb_r   <= nb_mem[ent_ra];
    rd_next_r <= next_mem[ent_ra];
    if (hop_we) hop_mem[hop_wa] <= hop_wd;
    rd_hop_r <= hop_mem[hop_ra];
    if (q_we) queue_mem[q_wa] <= q_wd;
    rd_q_r <= queue_mem[qh_r[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= '0;
    end else begin
      vis_r <= vis_nxt;
    end
  end

  always_comb begin
    push = 1'b0;
    push_data = '{status: rstat_r, vertex: 6'd0, distance: 6'd0, reached: 1'b0,
                  last: 1'b1};
    if (state_r == S_RESP && !skid_full) push = 1'b1;
    if (state_r == S_OUT_WR && !skid_full) begin
      push = 1'b1;
      push_data = '{status: ST_OK, vertex: ov_r[5:0],
                    distance: ov_vis ? rd_hop_r : 6'd0, reached: ov_vis,
                    last: (ov_r + 7'd1 == count)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      used_r     <= '0;
      head_vld_r <= '0;
      second_r   <= 1'b0;
      qh_r       <= '0;
      qt_r       <= '0;
      ov_r       <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          second_r <= 1'b0;
          if (acc) begin
            la_r <= fa[VW-1:0];
            lb_r <= fb[VW-1:0];
            case (func)
              FUNC_ADD: begin
                if (7'(fa) >= count || 7'(fb) >= count) begin
                  rstat_r <= ST_RANGE; state_r <= S_RESP;
                end else if (32'(used_r) + 32'(need) > 32'(MAX_ENTRIES)) begin
                  rstat_r <= ST_FULL; state_r <= S_RESP;
                end else begin
                  rstat_r <= ST_OK; state_r <= S_LHEAD;
                end
              end
              FUNC_RUN: begin
                if (7'(fa) >= count) begin
                  rstat_r <= ST_RANGE; state_r <= S_RESP;
                end else begin
                  qh_r <= '0; qt_r <= 7'd1; ov_r <= '0;
                  state_r <= S_QPOP;
                end
              end
              FUNC_CLEAR: begin
                head_vld_r <= '0; used_r <= '0;
                rstat_r <= ST_OK; state_r <= S_RESP;
              end
              default: ;
            endcase
          end
        end
        S_LHEAD: begin
          state_r <= S_LINK;
        end
        S_LINK: begin
          used_r <= used_r + CW'(1);
          head_vld_r[link_from] <= 1'b1;
          if (two_way_r && !second_r) begin
            second_r <= 1'b1;
            state_r  <= S_LHEAD;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!skid_full) state_r <= S_IDLE;
        end
        S_QPOP: begin
          // The queue read of entry qh is issued here.
          if (qh_r < qt_r && qh_r < 7'(MAX_VERTICES)) begin
            qh_r    <= qh_r + 7'd1;
            state_r <= S_HEAD;
          end else begin
            state_r <= S_OUT_RD;
          end
        end
        S_HEAD: begin
          // The dequeued vertex is valid now; its head and hop are read.
          state_r <= S_ENT_RD;
        end
        S_ENT_RD: begin
          if (!second_r) curhop_r <= rd_hop_r;
          e_r      <= e_nxt;
          second_r <= 1'b0;
          state_r  <= (e_nxt >= used_r) ? S_QPOP : S_ENT_CHK;
        end
        S_ENT_CHK: begin
          // Entry data arrive here; a new vertex is queued if not seen.
          if (q_we) qt_r <= qt_r + 7'd1;
          second_r <= 1'b1;
          state_r  <= S_ENT_RD;
        end
        S_OUT_RD: begin
          state_r <= S_OUT_WR;
        end
        S_OUT_WR: begin
          if (!skid_full) begin
            if (ov_r + 7'd1 == count) begin
              state_r <= S_IDLE;
            end else begin
              ov_r <= ov_r + 7'd1;
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BHD_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, state_r == S_IDLE)
  `BHD_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_r <= ENTRY_MAX)
  `BHD_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, qh_r <= qt_r)
  `BHD_ASSERT_NXT(a_link_grows, clk, rst_n, state_r == S_LINK, used_r == $past(used_r) + CW'(1))
endmodule
